// ===== hw/rtl/gfp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the gamepad frame parser.
package gfp_pkg;

  // Payload length in bytes (valid range 8 to 16)
  localparam int PAYLOAD_BYTES = 15;

  // Payload bytes kept for decoding (sticks, triggers, buttons)
  localparam int STORE_DEPTH = 8;
  localparam int CNT_W       = 4;
  localparam int QUEUE_DEPTH = 2;

  // Header bytes 'D', 'S', '4'
  localparam logic [7:0] HDR_0 = 8'h44;
  localparam logic [7:0] HDR_1 = 8'h53;
  localparam logic [7:0] HDR_2 = 8'h34;

  // Configuration register indexes
  localparam logic [1:0] CFG_STICK_CENTER  = 2'd0;
  localparam logic [1:0] CFG_DEADZONE_LOW  = 2'd1;
  localparam logic [1:0] CFG_DEADZONE_HIGH = 2'd2;

  // Configuration reset values
  localparam logic [7:0] RST_STICK_CENTER  = 8'd127;
  localparam logic [7:0] RST_DEADZONE_LOW  = 8'd117;
  localparam logic [7:0] RST_DEADZONE_HIGH = 8'd137;

  // Captured payload bytes 0..7 of one frame
  typedef logic [STORE_DEPTH-1:0][7:0] frame_t;

  typedef struct packed {
    logic [7:0] stick_center;
    logic [7:0] deadzone_low;
    logic [7:0] deadzone_high;
  } cfg_t;

  // Decoded record, last field in the lowest bits
  typedef struct packed {
    logic [7:0]        right_trigger;
    logic [7:0]        left_trigger;
    logic signed [8:0] right_y;
    logic signed [8:0] right_x;
    logic signed [8:0] left_y;
    logic signed [8:0] left_x;
    logic [7:0]        other_buttons;
    logic [7:0]        dpad_dirs;
    logic [3:0]        face_buttons;
  } record_t;

endpackage

// ===== hw/rtl/gfp_front.sv =====
`timescale 1ns / 1ps
// Header hunt and payload capture; pushes one frame per completed payload.
module gfp_front #(
  parameter int PAYLOAD_BYTES = gfp_pkg::PAYLOAD_BYTES
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,   // rx_byte[7:0]
  input  logic            q_full,
  output logic            q_push,
  output gfp_pkg::frame_t q_data
);

  localparam logic [gfp_pkg::CNT_W-1:0] LAST_IDX  = gfp_pkg::CNT_W'(PAYLOAD_BYTES - 1);
  localparam logic [gfp_pkg::CNT_W-1:0] STORE_CNT = gfp_pkg::CNT_W'(gfp_pkg::STORE_DEPTH);
  localparam int IDX_W = $clog2(gfp_pkg::STORE_DEPTH);

  typedef enum logic [1:0] {
    IDLE,
    GOT_D,
    GOT_S,
    CAPTURE
  } phase_t;

  phase_t                    phase;
  logic [gfp_pkg::CNT_W-1:0] count;
  gfp_pkg::frame_t           store;
  logic                      is_last;
  logic                      accept;
  logic                      store_wr;

  // Last payload byte needs a free queue slot
  assign is_last  = (phase == CAPTURE) && (count == LAST_IDX);
  assign s_tready = !is_last || !q_full;
  assign accept   = s_tvalid && s_tready;
  assign q_push   = accept && is_last;
  assign store_wr = (phase == CAPTURE) && (count < STORE_CNT);

  // Frame out: stored bytes, with the current beat forwarded into its slot
  always_comb begin
    for (int i = 0; i < gfp_pkg::STORE_DEPTH; i++) begin
      if (store_wr && (count[IDX_W-1:0] == IDX_W'(i))) begin
        q_data[i] = s_tdata;
      end else begin
        q_data[i] = store[i];
      end
    end
  end

  // Hunt state, payload counter and payload store
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= IDLE;
      count <= '0;
    end else if (accept) begin
      if (store_wr) begin
        store[count[IDX_W-1:0]] <= s_tdata;
      end
      unique case (phase)
        IDLE: begin
          phase <= (s_tdata == gfp_pkg::HDR_0) ? GOT_D : IDLE;
        end
        GOT_D: begin
          phase <= (s_tdata == gfp_pkg::HDR_1) ? GOT_S : IDLE;
        end
        GOT_S: begin
          if (s_tdata == gfp_pkg::HDR_2) begin
            phase <= CAPTURE;
            count <= '0;
          end else begin
            phase <= IDLE;
          end
        end
        CAPTURE: begin
          if (is_last) begin
            phase <= IDLE;
            count <= '0;
          end else begin
            count <= count + 1'b1;
          end
        end
        default: begin
          phase <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/gfp_queue.sv =====
`timescale 1ns / 1ps
// Small frame queue between the capture front and the decode back end.
module gfp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  gfp_pkg::frame_t push_data,
  output logic            full,
  output logic            not_empty,
  input  logic            pop,
  output gfp_pkg::frame_t head
);

  localparam int PTR_W  = $clog2(gfp_pkg::QUEUE_DEPTH);
  localparam int FILL_W = $clog2(gfp_pkg::QUEUE_DEPTH + 1);

  gfp_pkg::frame_t   mem [gfp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  assign full      = (fill == FILL_W'(gfp_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hw/rtl/gfp_back.sv =====
`timescale 1ns / 1ps
// Frame decode (buttons, D-pad, dead-zoned axes) into the output register.
module gfp_back (
  input  logic            clk,
  input  logic            rst,
  input  gfp_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  gfp_pkg::frame_t q_data,
  output logic            q_pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [71:0]     m_tdata
);

  gfp_pkg::record_t rec;
  logic [7:0]       pad;
  logic             n;
  logic             w;
  logic             s;
  logic             e;

  // Axis: zero inside the open dead zone, else offset from center mod 512
  function automatic logic [8:0] axis(input logic [7:0] raw, input logic negate,
                                      input gfp_pkg::cfg_t c);
    logic [8:0] res;
    if ((raw > c.deadzone_low) && (raw < c.deadzone_high)) begin
      res = '0;
    end else if (negate) begin
      res = {1'b0, c.stick_center} - {1'b0, raw};
    end else begin
      res = {1'b0, raw} - {1'b0, c.stick_center};
    end
    return res;
  endfunction

  assign pad = q_data[6];
  assign n   = pad[4];
  assign w   = pad[5];
  assign s   = pad[6];
  assign e   = pad[7];

  // Record decode from the queue head
  always_comb begin
    rec.face_buttons  = pad[3:0];
    rec.dpad_dirs     = {e & n, e, s & e, s, w & s, w, w & n, n};
    rec.other_buttons = q_data[7];
    rec.left_x        = axis(q_data[0], 1'b0, cfg);
    rec.left_y        = axis(q_data[1], 1'b1, cfg);
    rec.right_x       = axis(q_data[2], 1'b0, cfg);
    rec.right_y       = axis(q_data[3], 1'b1, cfg);
    rec.left_trigger  = q_data[4];
    rec.right_trigger = q_data[5];
  end

  // Load output register when empty or being drained
  assign q_pop = q_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_tdata <= rec;
    end
  end

endmodule

// ===== hw/rtl/gamepad_frame_parser_core.sv =====
`timescale 1ns / 1ps
// Gamepad frame parser top level: config registers, front capture, queue, back decode.
// Throughput: one rx byte per cycle; only the last payload byte waits, and only
// when the two-entry frame queue is full.
// After the last payload byte's beat the frame goes through the queue into the output register.
// Reset (rst, synchronous): hunt idle, queue and output empty, config to defaults.
module gamepad_frame_parser_core #(
  parameter int PAYLOAD_BYTES = gfp_pkg::PAYLOAD_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // rx_byte[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,    // face_buttons[3:0], dpad_dirs[11:4], other_buttons[19:12],
                                  // left_x[28:20], left_y[37:29], right_x[46:38],
                                  // right_y[55:47], left_trigger[63:56], right_trigger[71:64]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  gfp_pkg::cfg_t   cfg;
  logic            q_full;
  logic            q_push;
  logic            q_valid;
  logic            q_pop;
  gfp_pkg::frame_t push_data;
  gfp_pkg::frame_t head;

  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stick_center  <= gfp_pkg::RST_STICK_CENTER;
      cfg.deadzone_low  <= gfp_pkg::RST_DEADZONE_LOW;
      cfg.deadzone_high <= gfp_pkg::RST_DEADZONE_HIGH;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gfp_pkg::CFG_STICK_CENTER:  cfg.stick_center  <= cfg_data;
        gfp_pkg::CFG_DEADZONE_LOW:  cfg.deadzone_low  <= cfg_data;
        gfp_pkg::CFG_DEADZONE_HIGH: cfg.deadzone_high <= cfg_data;
        default: ;
      endcase
    end
  end

  gfp_front #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  gfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .not_empty (q_valid),
    .pop       (q_pop),
    .head      (head)
  );

  gfp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_data   (head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== sim/gfp_record_checker.sv =====
`timescale 1ns / 1ps
// Frame parser checker: mirrors the byte hunt and decode and compares each record beat.
module gfp_record_checker #(
  parameter int PAYLOAD_BYTES = gfp_pkg::PAYLOAD_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,    // rx_byte[7:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,    // face_buttons[3:0], dpad_dirs[11:4], other_buttons[19:12],
                                  // left_x[28:20], left_y[37:29], right_x[46:38],
                                  // right_y[55:47], left_trigger[63:56], right_trigger[71:64]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          pending,
  output int          fail_count
);

  typedef enum logic [1:0] {
    HUNT_IDLE,
    HUNT_GOT_D,
    HUNT_GOT_S,
    HUNT_CAPTURE
  } hunt_t;

  // Mirrored configuration
  logic [7:0] center;
  logic [7:0] dz_low;
  logic [7:0] dz_high;

  // Mirrored parser state
  hunt_t                     hunt;
  logic [gfp_pkg::CNT_W-1:0] pay_cnt;
  gfp_pkg::frame_t           cap_bytes;

  gfp_pkg::record_t pending_records[$];

  initial begin
    pending    = 0;
    fail_count = 0;
  end

  // Signed axis: zero strictly inside the dead zone, Y axes flipped
  function automatic logic signed [8:0] stick_axis(input logic [7:0] raw, input logic flip);
    logic [8:0] diff;
    if (raw > dz_low && raw < dz_high)
      return 9'sd0;
    if (flip)
      diff = {1'b0, center} - {1'b0, raw};
    else
      diff = {1'b0, raw} - {1'b0, center};
    return diff;
  endfunction

  // Decode the captured payload into one record
  function automatic gfp_pkg::record_t decode_frame();
    gfp_pkg::record_t rec;
    logic [7:0]       pad;
    logic             n, w, s, e;
    pad = cap_bytes[6];
    n   = pad[4];
    w   = pad[5];
    s   = pad[6];
    e   = pad[7];
    rec.face_buttons  = pad[3:0];
    rec.dpad_dirs     = {e & n, e, s & e, s, w & s, w, w & n, n};
    rec.other_buttons = cap_bytes[7];
    rec.left_x        = stick_axis(cap_bytes[0], 1'b0);
    rec.left_y        = stick_axis(cap_bytes[1], 1'b1);
    rec.right_x       = stick_axis(cap_bytes[2], 1'b0);
    rec.right_y       = stick_axis(cap_bytes[3], 1'b1);
    rec.left_trigger  = cap_bytes[4];
    rec.right_trigger = cap_bytes[5];
    return rec;
  endfunction

  // One rx byte through the header hunt / payload capture
  task automatic take_byte(input logic [7:0] b);
    case (hunt)
      HUNT_IDLE: begin
        if (b == gfp_pkg::HDR_0)
          hunt = HUNT_GOT_D;
      end
      HUNT_GOT_D: begin
        hunt = (b == gfp_pkg::HDR_1) ? HUNT_GOT_S : HUNT_IDLE;
      end
      HUNT_GOT_S: begin
        if (b == gfp_pkg::HDR_2) begin
          hunt    = HUNT_CAPTURE;
          pay_cnt = '0;
        end else begin
          hunt = HUNT_IDLE;
        end
      end
      default: begin
        if (int'(pay_cnt) < gfp_pkg::STORE_DEPTH)
          cap_bytes[pay_cnt[2:0]] = b;
        if (int'(pay_cnt) + 1 < PAYLOAD_BYTES) begin
          pay_cnt = pay_cnt + 1'b1;
        end else begin
          hunt    = HUNT_IDLE;
          pay_cnt = '0;
          pending_records.push_back(decode_frame());
        end
      end
    endcase
  endtask

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      fail_count++;
    end
  endtask

  // Monitor all three channels at each edge
  always @(posedge clk) begin : monitor
    gfp_pkg::record_t got;
    gfp_pkg::record_t want;
    if (rst) begin
      center    = gfp_pkg::RST_STICK_CENTER;
      dz_low    = gfp_pkg::RST_DEADZONE_LOW;
      dz_high   = gfp_pkg::RST_DEADZONE_HIGH;
      hunt      = HUNT_IDLE;
      pay_cnt   = '0;
      cap_bytes = '0;
      pending_records.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gfp_pkg::CFG_STICK_CENTER:  center  = cfg_data;
          gfp_pkg::CFG_DEADZONE_LOW:  dz_low  = cfg_data;
          gfp_pkg::CFG_DEADZONE_HIGH: dz_high = cfg_data;
          default: ;
        endcase
      end
      // record beat against the oldest decoded frame
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_records.size() == 0) begin
          $error("record beat with no frame behind it: %h", m_tdata);
          fail_count++;
        end else begin
          want = pending_records.pop_front();
          check_field("face_buttons", want.face_buttons, got.face_buttons);
          check_field("dpad_dirs", want.dpad_dirs, got.dpad_dirs);
          check_field("other_buttons", want.other_buttons, got.other_buttons);
          check_field("left_x", want.left_x, got.left_x);
          check_field("left_y", want.left_y, got.left_y);
          check_field("right_x", want.right_x, got.right_x);
          check_field("right_y", want.right_y, got.right_y);
          check_field("left_trigger", want.left_trigger, got.left_trigger);
          check_field("right_trigger", want.right_trigger, got.right_trigger);
        end
      end
      if (s_tvalid && s_tready)
        take_byte(s_tdata);
    end
    pending <= pending_records.size();
  end

endmodule

// ===== sim/gamepad_frame_parser_core_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the gamepad frame parser: stimulus, backpressure and verdict.
module gamepad_frame_parser_core_test;

  localparam int         NUM_PHASES     = 6;
  localparam int         PHASE_ITEMS    = 230;
  localparam int         SETTLE_CYCLES  = 8;
  localparam int         WATCHDOG_LIMIT = 3000;
  localparam int         HOLD_AT_BEAT   = 500;
  localparam int         HOLD_CYCLES    = 300;
  localparam logic [1:0] CFG_UNUSED     = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [7:0]  cfg_data = 8'h00;

  int rec_pending;
  int chk_fails;
  int rx_beats   = 0;
  int rec_beats  = 0;
  int quiet      = 0;
  int sent_items = 0;
  bit burst      = 1'b0;
  bit hold_done  = 1'b0;

  // Current settings, used only to aim stick bytes at the dead-zone edges
  logic [7:0] cur_center = gfp_pkg::RST_STICK_CENTER;
  logic [7:0] cur_lo     = gfp_pkg::RST_DEADZONE_LOW;
  logic [7:0] cur_hi     = gfp_pkg::RST_DEADZONE_HIGH;

  always #6 clk = ~clk;

  gamepad_frame_parser_core #(.PAYLOAD_BYTES(gfp_pkg::PAYLOAD_BYTES)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gfp_record_checker #(.PAYLOAD_BYTES(gfp_pkg::PAYLOAD_BYTES)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (rec_pending),
    .fail_count (chk_fails)
  );

  // Beat counters and the no-progress counter
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (s_tvalid && s_tready)
      rx_beats <= rx_beats + 1;
    if (m_tvalid && m_tready)
      rec_beats <= rec_beats + 1;
  end

  // Watchdog
  always @(posedge clk) begin
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", quiet);
      $display("FAILURE");
      $finish;
    end
  end

  // Sender gap: none in burst stretches, otherwise mostly short, a few long
  function automatic int pick_gap();
    int r;
    if (burst)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 93)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Record receiver: random ready, one long hold-off while bytes keep coming
  initial begin
    do @(posedge clk); while (rst);
    forever begin
      if (!hold_done && rx_beats >= HOLD_AT_BEAT) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= 1'b1;
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(60, 150)) @(posedge clk);
      else
        repeat ($urandom_range(1, 12)) @(posedge clk);
      if ($urandom_range(0, 2) != 0) begin
        m_tready <= 1'b0;
        if ($urandom_range(0, 11) == 0)
          repeat ($urandom_range(15, 40)) @(posedge clk);
        else
          repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
  end

  // One rx beat; valid stays high across back-to-back bytes
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_items++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drain all records, then let the back end settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (rec_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] other_than(input logic [7:0] x);
    logic [7:0] v;
    v = 8'($urandom);
    while (v == x) v = 8'($urandom);
    return v;
  endfunction

  // Stick bytes aimed at center, dead-zone edges and rails
  function automatic logic [7:0] stick_byte();
    logic [7:0] v;
    v = 8'($urandom);
    case ($urandom_range(0, 9))
      0: v = cur_center;
      1: v = cur_lo;
      2: v = cur_lo + 8'd1;
      3: v = cur_hi;
      4: v = cur_hi - 8'd1;
      5: v = 8'h00;
      6: v = 8'hFF;
      default: ;
    endcase
    return v;
  endfunction

  // Noise leaning on header bytes so partial headers show up
  function automatic logic [7:0] noise_byte();
    logic [7:0] v;
    v = 8'($urandom);
    case ($urandom_range(0, 5))
      0: v = gfp_pkg::HDR_0;
      1: v = gfp_pkg::HDR_1;
      2: v = gfp_pkg::HDR_2;
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_frame();
    logic [7:0] v;
    send_byte(gfp_pkg::HDR_0);
    send_byte(gfp_pkg::HDR_1);
    send_byte(gfp_pkg::HDR_2);
    for (int i = 0; i < gfp_pkg::PAYLOAD_BYTES; i++) begin
      v = 8'($urandom);
      if (i < 4)
        v = stick_byte();
      else if (i < 6 && $urandom_range(0, 3) == 0)
        v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      send_byte(v);
    end
  endtask

  // Mostly full frames, some broken headers and some noise
  task automatic send_sequence();
    int r;
    if ($urandom_range(0, 5) == 0)
      burst = !burst;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      send_frame();
    end else if (r < 90) begin
      send_byte(gfp_pkg::HDR_0);
      if ($urandom_range(0, 1)) begin
        send_byte(other_than(gfp_pkg::HDR_1));
      end else begin
        send_byte(gfp_pkg::HDR_1);
        send_byte(other_than(gfp_pkg::HDR_2));
      end
    end else begin
      repeat ($urandom_range(1, 6)) send_byte(noise_byte());
    end
  endtask

  // Dead-zone settings per phase; the unused index is written each time too
  task automatic apply_setting(input int ph);
    logic [7:0] c, lo, hi;
    c  = gfp_pkg::RST_STICK_CENTER;
    lo = gfp_pkg::RST_DEADZONE_LOW;
    hi = gfp_pkg::RST_DEADZONE_HIGH;
    case (ph)
      1: begin c = 8'd0;   lo = 8'd255; hi = 8'd0;   end   // bounds crossed
      2: begin c = 8'd255; lo = 8'd0;   hi = 8'd255; end   // widest zone
      3: begin c = 8'd128; lo = 8'd100; hi = 8'd101; end   // low = high - 1, empty
      4: begin
        c  = 8'($urandom);
        lo = 8'($urandom_range(0, 200));
        hi = lo + 8'($urandom_range(2, 55));
      end
      default: ;
    endcase
    write_reg(CFG_UNUSED, 8'($urandom));
    if (ph > 0) begin
      write_reg(gfp_pkg::CFG_STICK_CENTER, c);
      write_reg(gfp_pkg::CFG_DEADZONE_LOW, lo);
      write_reg(gfp_pkg::CFG_DEADZONE_HIGH, hi);
    end
    cur_center = c;
    cur_lo     = lo;
    cur_hi     = hi;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0)
        wait_idle();
      apply_setting(ph);
      if (ph == 0) begin
        // wrong second byte is a 'D' and gets consumed; 'S','4' while idle do nothing
        send_byte(gfp_pkg::HDR_0);
        send_byte(gfp_pkg::HDR_0);
        send_byte(gfp_pkg::HDR_1);
        send_byte(gfp_pkg::HDR_2);
        // wrong third header byte
        send_byte(gfp_pkg::HDR_0);
        send_byte(gfp_pkg::HDR_1);
        send_byte(gfp_pkg::HDR_1);
        // full frame: rail sticks, one inside the zone, one on its edge
        send_byte(gfp_pkg::HDR_0);
        send_byte(gfp_pkg::HDR_1);
        send_byte(gfp_pkg::HDR_2);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'd118);
        send_byte(8'd117);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hF5);
        send_byte(8'hA5);
        repeat (gfp_pkg::PAYLOAD_BYTES - 8) send_byte(8'($urandom));
      end
      while (sent_items < (ph + 1) * PHASE_ITEMS)
        send_sequence();
    end

    wait_idle();
    $display("Run covered %0d rx bytes and %0d decoded records over %0d dead-zone settings",
             rx_beats, rec_beats, NUM_PHASES);
    if (chk_fails == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
